// ----- rtl/rsame_pkg.sv -----
// Package for the RSA modular exponentiation block.
// Holds the shared constants, configuration register indexes and state types.
// No dependencies.
package rsame_pkg;

  // Default operand width and the value the exponent register takes at reset.
  localparam int unsigned DEFAULT_WORD_BITS = 32;
  localparam logic [63:0] RESET_EXPONENT    = 64'd65537;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_BITS = 1;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_EXPONENT = 1'b0,
    CFG_MODULUS  = 1'b1
  } cfg_reg_t;

  // Sequencer states of the shared modular multiplier.
  typedef enum logic [1:0] {
    MM_IDLE,
    MM_DBL,
    MM_ADD
  } mm_state_t;

  // Sequencer states of the exponentiation controller.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_OUT
  } exp_state_t;

  // Status returned by the modular multiplier to the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// ----- rtl/rsame_mulmod.sv -----
// Shared modular multiplier: (a * b) mod m by double-and-add, MSB of b first.
// One modular add (add, compare, subtract) per cycle. Depends on rsame_pkg.
module rsame_mulmod
  import rsame_pkg::*;
#(
  parameter int unsigned WORD_BITS = DEFAULT_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] op_a,
  input  logic [WORD_BITS-1:0] op_b,
  input  logic [WORD_BITS-1:0] op_m,
  output logic [WORD_BITS-1:0] product,
  output mm_stat_t             stat
);

  localparam int unsigned CNT_BITS = $clog2(WORD_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

  mm_state_t             state_r, state_nxt;
  logic [WORD_BITS-1:0]  a_r, a_nxt;
  logic [WORD_BITS-1:0]  b_r, b_nxt;
  logic [WORD_BITS-1:0]  m_r, m_nxt;
  logic [WORD_BITS-1:0]  r_r, r_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;

  logic [WORD_BITS-1:0]  addend;
  logic [WORD_BITS:0]    sum;
  logic [WORD_BITS:0]    diff;
  logic [WORD_BITS-1:0]  addmod;

  // The single modular adder: r + r while doubling, r + a while adding.
  // Both operands lie below m, so one conditional subtraction suffices.
  assign addend = (state_r == MM_ADD) ? a_r : r_r;
  assign sum    = {1'b0, r_r} + {1'b0, addend};
  assign diff   = sum - {1'b0, m_r};
  assign addmod = (sum >= {1'b0, m_r}) ? diff[WORD_BITS-1:0] : sum[WORD_BITS-1:0];

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
  end

  // Sequencer: one doubling per multiplier bit, plus an add where the bit is set.
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    m_nxt     = m_r;
    r_nxt     = r_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      MM_IDLE: begin
        if (start) begin
          a_nxt     = op_a;
          b_nxt     = op_b;
          m_nxt     = op_m;
          r_nxt     = '0;
          cnt_nxt   = CNT_LAST;
          state_nxt = MM_DBL;
        end
      end
      MM_DBL: begin
        r_nxt = addmod;
        if (b_r[WORD_BITS-1]) begin
          state_nxt = MM_ADD;
        end else if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = MM_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          b_nxt   = b_r << 1;
        end
      end
      MM_ADD: begin
        r_nxt = addmod;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = MM_IDLE;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          b_nxt     = b_r << 1;
          state_nxt = MM_DBL;
        end
      end
      default: begin
        state_nxt = MM_IDLE;
      end
    endcase
  end

  assign product   = r_r;
  assign stat.busy = (state_r != MM_IDLE);
  assign stat.done = done_r;

endmodule

// ----- rtl/rsa_modular_exponentiation.sv -----
// Top level of the RSA modular exponentiation block: controller, registers, output stage.
// Depends on rsame_pkg and rsame_mulmod.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_message_word
//   out_     output     out_valid/out_ready  out_result_word
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// Each modular multiplication takes WORD_BITS doublings plus one add per set bit
// of its multiplier.
// A word needs one reduction of the message, one multiply per set exponent bit and one
// squaring per exponent bit below the top one.
// An exponent of zero or a modulus of zero gives the result without the multiplier.
// in_ready is high only while the controller is idle; a result that waits on out_ready
// holds the next one in the controller. Reset loads exponent 65537 and modulus 1.
module rsa_modular_exponentiation
  import rsame_pkg::*;
#(
  parameter int unsigned WORD_BITS = DEFAULT_WORD_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [WORD_BITS-1:0]      in_message_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [WORD_BITS-1:0]      out_result_word,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]      cfg_wdata
);

  exp_state_t            state_r, state_nxt;
  logic [WORD_BITS-1:0]  exponent_r;
  logic [WORD_BITS-1:0]  modulus_r;
  logic [WORD_BITS-1:0]  e_r, e_nxt;
  logic [WORD_BITS-1:0]  x_r, x_nxt;
  logic [WORD_BITS-1:0]  acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0]  out_word_r, out_word_nxt;

  logic                  mm_start;
  logic [WORD_BITS-1:0]  mm_a;
  logic [WORD_BITS-1:0]  mm_b;
  logic [WORD_BITS-1:0]  mm_product;
  mm_stat_t              mm_stat;

  logic [WORD_BITS-1:0]  one_mod;
  logic                  e_last;
  logic                  out_free;

  // 1 mod m: zero when the modulus is one.
  assign one_mod  = WORD_BITS'(modulus_r != WORD_BITS'(1));
  // True when no exponent bit remains above the current one.
  assign e_last   = (e_r[WORD_BITS-1:1] == '0);
  assign out_free = !out_valid_r || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= WORD_BITS'(RESET_EXPONENT);
      modulus_r  <= WORD_BITS'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_EXPONENT) begin
        exponent_r <= cfg_wdata;
      end
      if (cfg_index == CFG_MODULUS) begin
        modulus_r <= cfg_wdata;
      end
    end
  end

  // Controller state, working registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    e_r        <= e_nxt;
    x_r        <= x_nxt;
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
  end

  // Square-and-multiply over the exponent, least significant bit first.
  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mm_start      = 1'b0;
    mm_a          = x_r;
    mm_b          = x_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          e_nxt = exponent_r;
          if (exponent_r == '0) begin
            acc_nxt   = WORD_BITS'(1);
            state_nxt = ST_OUT;
          end else if (modulus_r == '0) begin
            acc_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            // Reduce the message as (1 mod m) * message mod m.
            mm_start  = 1'b1;
            mm_a      = one_mod;
            mm_b      = in_message_word;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          x_nxt     = mm_product;
          acc_nxt   = one_mod;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (e_r[0]) begin
          mm_start  = 1'b1;
          mm_a      = acc_r;
          mm_b      = x_r;
          state_nxt = ST_MUL;
        end else begin
          e_nxt = e_r >> 1;
          if (e_last) begin
            state_nxt = ST_OUT;
          end else begin
            mm_start  = 1'b1;
            state_nxt = ST_SQR;
          end
        end
      end
      ST_MUL: begin
        if (mm_stat.done) begin
          acc_nxt = mm_product;
          e_nxt   = e_r >> 1;
          if (e_last) begin
            state_nxt = ST_OUT;
          end else begin
            mm_start  = 1'b1;
            state_nxt = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mm_stat.done) begin
          x_nxt     = mm_product;
          state_nxt = ST_STEP;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_word_nxt  = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Shared modular multiplier.
  rsame_mulmod #(
    .WORD_BITS (WORD_BITS)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .op_m    (modulus_r),
    .product (mm_product),
    .stat    (mm_stat)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;

endmodule

// ----- rtl/rsame_checker.sv -----
// Port-level checker for the RSA modular exponentiation block, with its bind.
// Depends on rsame_pkg and the top level rsa_modular_exponentiation.
module rsame_checker
  import rsame_pkg::*;
#(
  parameter int unsigned WORD_BITS = DEFAULT_WORD_BITS
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] out_result_word
);

  // A stalled input transaction stays offered.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn before acceptance");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_word))
    else $error("stalled result changed or dropped");

  // The block is busy in the cycle after taking a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready still high after an accepted transaction");

  // A new result only appears while the block was working on a transaction.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // With nothing in progress, a taken result is not followed by another.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && in_ready |=> !out_valid)
    else $error("result produced without an input transaction");

endmodule

bind rsa_modular_exponentiation rsame_checker #(
  .WORD_BITS (WORD_BITS)
) u_rsame_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_word (out_result_word)
);
